### hdl/ip_range_set_address_sweep_macros.svh
// assertion macros shared by the sweep block
`ifndef IP_RANGE_SET_ADDRESS_SWEEP_MACROS_SVH
`define IP_RANGE_SET_ADDRESS_SWEEP_MACROS_SVH

// same-cycle implication, reset masks the check
`define IPRAS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipras check failed");

// next-cycle implication, reset masks the check
`define IPRAS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipras check failed");

`endif

### hdl/ipras_pkg.sv
// shared types and constants of the ip range sweep block
package ipras_pkg;

  localparam int MAX_RANGES_DEF = 16;
  localparam int MAX_GROUPS     = 8;
  localparam int V4_GROUPS      = 4;

  typedef enum logic [1:0] {
    FUNC_WR_BOUNDS = 2'd0,
    FUNC_WR_HDR    = 2'd1,
    FUNC_RESTART   = 2'd2,
    FUNC_NEXT      = 2'd3
  } func_t;

  typedef struct packed {
    func_t       func;
    logic [3:0]  entry;
    logic [2:0]  group;
    logic [15:0] from_value;
    logic [15:0] to_value;
    logic        is_v6;
    logic        masked;
  } in_item_t;

  typedef struct packed {
    logic [63:0] address_upper;
    logic [63:0] address_lower;
    logic        out_is_v6;
    logic [3:0]  range_index;
    logic        status;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic load_run;
    logic load_sel_j;
    logic k_zero;
    logic k_inc;
    logic first;
    logic step_init;
    logic step_do;
    logic j_zero;
    logic j_inc;
    logic skip_init;
    logic s_dec;
    logic skip_apply;
    logic emit;
    logic emit_done;
  } cmd_t;

  typedef struct packed {
    logic num_zero;
    logic k_ge_num;
    logic k_last;
    logic k_zero;
    logic load_done;
    logic inc;
    logic i_zero;
    logic masked_k;
    logic at_top;
    logic covers;
    logic j_last;
    logic skip_cont;
    logic changed;
    logic top_after;
    logic out_free;
  } status_t;

endpackage

### hdl/ipras_ctrl.sv
// sequencer of the sweep: loads, steps, cover checks and skips
module ipras_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  ipras_pkg::func_t   func,
  input  ipras_pkg::status_t st,
  output logic               in_stall,
  output ipras_pkg::cmd_t    cmd
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_LOADK = 14'b00000000000010,
    S_FIRST = 14'b00000000000100,
    S_STEP  = 14'b00000000001000,
    S_NEXT  = 14'b00000000010000,
    S_TOP   = 14'b00000000100000,
    S_ADV   = 14'b00000001000000,
    S_CHKJ  = 14'b00000010000000,
    S_LOADJ = 14'b00000100000000,
    S_COVER = 14'b00001000000000,
    S_SKIPS = 14'b00010000000000,
    S_SKIPA = 14'b00100000000000,
    S_EMIT  = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  typedef enum logic [1:0] {
    P_RESTART = 2'd0,
    P_NEXT    = 2'd1,
    P_ADV     = 2'd2
  } path_t;

  state_t state_r, state_nxt;
  path_t  path_r, path_nxt;
  logic   ended_r, ended_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    path_nxt  = path_r;
    ended_nxt = ended_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (func)
            ipras_pkg::FUNC_RESTART: begin
              if (st.num_zero) begin
                state_nxt = S_DONE;
              end else begin
                cmd.k_zero = 1'b1;
                path_nxt   = P_RESTART;
                state_nxt  = S_LOADK;
              end
            end
            ipras_pkg::FUNC_NEXT: begin
              ended_nxt = 1'b0;
              if (st.num_zero || st.k_ge_num) begin
                state_nxt = S_DONE;
              end else begin
                path_nxt  = P_NEXT;
                state_nxt = S_LOADK;
              end
            end
            default: ;
          endcase
        end
      end
      S_LOADK: begin
        cmd.load_run = 1'b1;
        if (st.load_done) begin
          state_nxt = (path_r == P_NEXT) ? S_STEP : S_FIRST;
        end
      end
      S_FIRST: begin
        cmd.first = 1'b1;
        state_nxt = (path_r == P_RESTART) ? S_EMIT : S_CHKJ;
      end
      S_STEP: begin
        cmd.step_init = 1'b1;
        if (ended_r) begin
          ended_nxt = 1'b0;
          state_nxt = S_ADV;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        cmd.step_do = 1'b1;
        if (st.inc) begin
          state_nxt = st.masked_k ? S_TOP : S_CHKJ;
        end else if (st.i_zero) begin
          state_nxt = S_ADV;
        end
      end
      S_TOP: begin
        state_nxt = st.at_top ? S_ADV : S_CHKJ;
      end
      S_ADV: begin
        cmd.k_inc = 1'b1;
        if (st.k_last) begin
          state_nxt = S_DONE;
        end else begin
          path_nxt  = P_ADV;
          state_nxt = S_LOADK;
        end
      end
      S_CHKJ: begin
        cmd.j_zero = 1'b1;
        state_nxt  = st.k_zero ? S_EMIT : S_LOADJ;
      end
      S_LOADJ: begin
        cmd.load_run   = 1'b1;
        cmd.load_sel_j = 1'b1;
        if (st.load_done) begin
          state_nxt = S_COVER;
        end
      end
      S_COVER: begin
        if (st.covers) begin
          cmd.skip_init = 1'b1;
          state_nxt     = S_SKIPS;
        end else begin
          cmd.j_inc = 1'b1;
          state_nxt = st.j_last ? S_EMIT : S_LOADJ;
        end
      end
      S_SKIPS: begin
        if (st.skip_cont) begin
          cmd.s_dec = 1'b1;
        end else begin
          state_nxt = S_SKIPA;
        end
      end
      S_SKIPA: begin
        cmd.skip_apply = 1'b1;
        ended_nxt      = st.changed && st.top_after;
        state_nxt      = S_STEP;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.emit_done = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      path_r  <= P_NEXT;
      ended_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      path_r  <= path_nxt;
      ended_r <= ended_nxt;
    end
  end

endmodule

### hdl/ipras_dp.sv
// range tables, sweep registers, comparators and result register
module ipras_dp #(
  parameter int MAX_RANGES = ipras_pkg::MAX_RANGES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ipras_pkg::in_item_t in_data,
  input  logic [4:0]          act_num,
  input  ipras_pkg::cmd_t     cmd,
  output ipras_pkg::status_t  st,
  output logic                out_valid,
  input  logic                out_stall,
  output ipras_pkg::out_item_t out_data
);

  localparam int EW    = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int GW    = $clog2(ipras_pkg::MAX_GROUPS);
  localparam int DEPTH = MAX_RANGES * ipras_pkg::MAX_GROUPS;
  localparam int NG    = ipras_pkg::MAX_GROUPS;

  logic [31:0] bnd_mem [DEPTH];
  logic [1:0]  hdr_mem [MAX_RANGES];
  logic [31:0] bnd_rd_r;
  logic [1:0]  hdr_rd_r;

  logic [15:0] cur_r [NG];
  logic [15:0] cur_nxt [NG];
  logic [15:0] lo_k_r [NG];
  logic [15:0] hi_k_r [NG];
  logic [15:0] lo_j_r [NG];
  logic [15:0] hi_j_r [NG];
  logic [1:0]  hdr_k_r, hdr_j_r;
  logic [15:0] tgt [NG];

  logic [4:0]    k_r, j_r;
  logic [GW-1:0] i_r, s_r;
  logic [GW:0]   cnt_r;
  logic [4:0]    ld_entry;
  logic [GW-1:0] cap_idx;
  logic [GW-1:0] n_k_last;
  logic          v6_k, v6_j;
  logic          out_valid_r;
  ipras_pkg::out_item_t out_r;

  // table writes
  always_ff @(posedge clk) begin
    if (cmd.accept && (in_data.func == ipras_pkg::FUNC_WR_BOUNDS) &&
        (32'(in_data.entry) < MAX_RANGES)) begin
      bnd_mem[{EW'(in_data.entry), in_data.group}] <= {in_data.to_value, in_data.from_value};
    end
    bnd_rd_r <= bnd_mem[{EW'(ld_entry), cnt_r[GW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && (in_data.func == ipras_pkg::FUNC_WR_HDR) &&
        (32'(in_data.entry) < MAX_RANGES)) begin
      hdr_mem[EW'(in_data.entry)] <= {in_data.masked, in_data.is_v6};
    end
    hdr_rd_r <= hdr_mem[EW'(ld_entry)];
  end

  assign ld_entry = cmd.load_sel_j ? j_r : k_r;
  assign cap_idx  = GW'(cnt_r - 1'b1);
  assign v6_k     = hdr_k_r[0];
  assign v6_j     = hdr_j_r[0];
  assign n_k_last = v6_k ? GW'(NG - 1) : GW'(ipras_pkg::V4_GROUPS - 1);

  // captured copies of the two entries in use
  always_ff @(posedge clk) begin
    if (cmd.load_run && (cnt_r != '0)) begin
      if (cmd.load_sel_j) begin
        lo_j_r[cap_idx] <= bnd_rd_r[15:0];
        hi_j_r[cap_idx] <= bnd_rd_r[31:16];
      end else begin
        lo_k_r[cap_idx] <= bnd_rd_r[15:0];
        hi_k_r[cap_idx] <= bnd_rd_r[31:16];
      end
    end
    if (cmd.load_run && (cnt_r == (GW+1)'(1))) begin
      if (cmd.load_sel_j) begin
        hdr_j_r <= hdr_rd_r;
      end else begin
        hdr_k_r <= hdr_rd_r;
      end
    end
  end

  // status
  logic at_top, covers, inside_s, changed, top_after;
  logic [15:0] top_s;

  always_comb begin
    at_top = 1'b1;
    covers = 1'b1;
    for (int g = 0; g < NG; g++) begin
      if ((g < ipras_pkg::V4_GROUPS || v6_k) && (cur_r[g] != hi_k_r[g])) begin
        at_top = 1'b0;
      end
      if ((g < ipras_pkg::V4_GROUPS || v6_j) &&
          ((cur_r[g] < lo_j_r[g]) || (cur_r[g] > hi_j_r[g]))) begin
        covers = 1'b0;
      end
    end
  end

  always_comb begin
    logic s_in_j;
    s_in_j = v6_j || (s_r < GW'(ipras_pkg::V4_GROUPS));
    if ((cur_r[s_r] >= hi_k_r[s_r]) && (lo_k_r[s_r] >= hi_k_r[s_r])) begin
      inside_s = 1'b1;
    end else if ((cur_r[s_r] < lo_k_r[s_r]) || (cur_r[s_r] > hi_k_r[s_r])) begin
      inside_s = 1'b0;
    end else if (!s_in_j) begin
      inside_s = 1'b1;
    end else begin
      inside_s = (lo_j_r[s_r] <= lo_k_r[s_r]) && (hi_k_r[s_r] <= hi_j_r[s_r]);
    end
    top_s = hi_k_r[s_r];
    if (s_in_j && (hi_j_r[s_r] < top_s)) begin
      top_s = hi_j_r[s_r];
    end
  end

  always_comb begin
    changed   = 1'b0;
    top_after = (hdr_k_r == 2'b10);
    for (int g = 0; g < NG; g++) begin
      tgt[g] = cur_r[g];
      if (GW'(g) == s_r) begin
        if (top_s > cur_r[g]) begin
          tgt[g] = top_s;
        end
      end else if ((GW'(g) > s_r) && (GW'(g) <= n_k_last)) begin
        if (cur_r[g] < hi_k_r[g]) begin
          tgt[g] = hi_k_r[g];
        end
      end
      if (tgt[g] != cur_r[g]) begin
        changed = 1'b1;
      end
      if ((GW'(g) <= n_k_last) && (tgt[g] != hi_k_r[g])) begin
        top_after = 1'b0;
      end
    end
  end

  assign st.num_zero  = (act_num == '0);
  assign st.k_ge_num  = (k_r >= act_num);
  assign st.k_last    = ({1'b0, k_r} + 6'd1) >= {1'b0, act_num};
  assign st.k_zero    = (k_r == '0);
  assign st.load_done = (cnt_r == (GW+1)'(NG));
  assign st.inc       = (cur_r[i_r] < hi_k_r[i_r]);
  assign st.i_zero    = (i_r == '0);
  assign st.masked_k  = (hdr_k_r == 2'b10);
  assign st.at_top    = at_top;
  assign st.covers    = covers;
  assign st.j_last    = ((j_r + 5'd1) == k_r);
  assign st.skip_cont = (s_r != '0) && inside_s;
  assign st.changed   = changed;
  assign st.top_after = top_after;
  assign st.out_free  = !out_valid_r || !out_stall;

  // current address update
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      cur_nxt[g] = cur_r[g];
    end
    if (cmd.first) begin
      for (int g = 0; g < NG; g++) begin
        if (GW'(g) <= n_k_last) begin
          cur_nxt[g] = lo_k_r[g];
        end
      end
      if (hdr_k_r == 2'b10) begin
        cur_nxt[ipras_pkg::V4_GROUPS-1] = lo_k_r[ipras_pkg::V4_GROUPS-1] + 16'd1;
      end
    end else if (cmd.step_do) begin
      if (cur_r[i_r] < hi_k_r[i_r]) begin
        cur_nxt[i_r] = cur_r[i_r] + 16'd1;
      end else if (lo_k_r[i_r] < hi_k_r[i_r]) begin
        cur_nxt[i_r] = lo_k_r[i_r];
      end
    end else if (cmd.skip_apply) begin
      for (int g = 0; g < NG; g++) begin
        cur_nxt[g] = tgt[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < NG; g++) begin
        cur_r[g] <= '0;
      end
      k_r         <= '0;
      j_r         <= '0;
      i_r         <= '0;
      s_r         <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int g = 0; g < NG; g++) begin
        cur_r[g] <= cur_nxt[g];
      end
      cnt_r <= cmd.load_run ? cnt_r + 1'b1 : '0;
      if (cmd.k_zero) begin
        k_r <= '0;
      end else if (cmd.k_inc) begin
        k_r <= k_r + 5'd1;
      end
      if (cmd.j_zero) begin
        j_r <= '0;
      end else if (cmd.j_inc) begin
        j_r <= j_r + 5'd1;
      end
      if (cmd.step_init) begin
        i_r <= n_k_last;
      end else if (cmd.step_do && !st.inc) begin
        i_r <= i_r - 1'b1;
      end
      if (cmd.skip_init) begin
        s_r <= n_k_last;
      end else if (cmd.s_dec) begin
        s_r <= s_r - 1'b1;
      end
      if (cmd.emit || cmd.emit_done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit_done) begin
      out_r <= '{status: 1'b1, default: '0};
    end else if (cmd.emit) begin
      if (v6_k) begin
        out_r.address_upper <= {cur_r[0], cur_r[1], cur_r[2], cur_r[3]};
        out_r.address_lower <= {cur_r[4], cur_r[5], cur_r[6], cur_r[7]};
      end else begin
        out_r.address_upper <= '0;
        out_r.address_lower <= {32'd0, cur_r[0][7:0], cur_r[1][7:0],
                                cur_r[2][7:0], cur_r[3][7:0]};
      end
      out_r.out_is_v6   <= v6_k;
      out_r.range_index <= k_r[3:0];
      out_r.status      <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### hdl/ip_range_set_address_sweep.sv
// IP range sweep: holds up to MAX_RANGES range entries (IPv4 or IPv6, a
// from/to pair per group) and hands out the next address of the sweep on
// each next transaction. Bound and header writes are taken while idle and
// leave the block idle. A restart reads entry 0's eight groups from the bounds
// memory (one group per cycle over its single read port), sets the first
// address of the entry and registers the result. A next transaction loads
// the current entry, sets up the step and steps its groups from the last one
// down; then each earlier entry is loaded and checked for cover. A cover skip
// searches the groups of the entry and applies the skip before the step is
// taken again, and a step that exhausts an entry adds a further load of the
// next entry. So the time per address grows with the entry index.
// Results are held in an output register, so a waiting result does not stop
// the next transaction from being taken. num_ranges is written through the
// APB-style port at address 0; values above MAX_RANGES act as MAX_RANGES.
`include "ip_range_set_address_sweep_macros.svh"

module ip_range_set_address_sweep #(
  parameter int MAX_RANGES = ipras_pkg::MAX_RANGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input transactions
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ipras_pkg::in_item_t  in_data,
  // result transactions
  output logic                 out_valid,
  input  logic                 out_stall,
  output ipras_pkg::out_item_t out_data,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [4:0]         num_r;
  logic [4:0]         act_num;
  ipras_pkg::cmd_t    cmd;
  ipras_pkg::status_t st;

  // register 0 is num_ranges, the upper word is unused
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {27'd0, num_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      num_r <= pwdata[4:0];
    end
  end

  // clamp the entry count to what the table holds
  assign act_num = (32'(num_r) > MAX_RANGES) ? 5'(MAX_RANGES) : num_r;

  ipras_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .func     (in_data.func),
    .st       (st),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  ipras_dp #(
    .MAX_RANGES (MAX_RANGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .act_num   (act_num),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // an end-of-sweep result carries nothing but its status
  `IPRAS_ASSERT_IMP(a_done_clean, out_valid && out_data.status, (out_data.address_upper == '0) && (out_data.address_lower == '0) && !out_data.out_is_v6 && (out_data.range_index == '0))

  // an IPv4 result only fills the low 32 bits
  `IPRAS_ASSERT_IMP(a_v4_width, out_valid && !out_data.out_is_v6, (out_data.address_upper == '0) && (out_data.address_lower[63:32] == '0))

  // a restart or next transaction always keeps the block busy for a while
  `IPRAS_ASSERT_NXT(a_busy_after_req, in_valid && !in_stall && ((in_data.func == ipras_pkg::FUNC_RESTART) || (in_data.func == ipras_pkg::FUNC_NEXT)), in_stall)

endmodule
